// ===== sv/kji_pkg.sv =====
// Shared constants, pose table and request/response types of the keyframe joint interpolator.
package kji_pkg;

  localparam int JOINT_COUNT = 12;
  localparam int POSE_COUNT  = 3;
  localparam int ANGLE_BITS  = 16;
  localparam int GAIN_BITS   = 16;
  localparam int TICK_BITS   = 18;
  localparam int FRAC_BITS   = 17;
  localparam int DIGIT_BITS  = 4;
  localparam int DIGITS      = 5;
  localparam int JOINT_BITS  = 4;
  localparam int SEG_BITS    = 2;

  localparam logic [JOINT_BITS-1:0] LAST_JOINT = JOINT_BITS'(JOINT_COUNT - 1);
  localparam logic [SEG_BITS-1:0]   LAST_SEG   = SEG_BITS'(POSE_COUNT - 1);

  // Input item commands
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_SEG_ONE   = 3'd0;
  localparam logic [2:0] REG_SEG_TWO   = 3'd1;
  localparam logic [2:0] REG_SEG_THREE = 3'd2;
  localparam logic [2:0] REG_STIFFNESS = 3'd3;
  localparam logic [2:0] REG_DAMPING   = 3'd4;

  localparam logic [15:0] SEG_ONE_RESET   = 16'd500;
  localparam logic [15:0] SEG_TWO_RESET   = 16'd500;
  localparam logic [15:0] SEG_THREE_RESET = 16'd1000;
  localparam logic [15:0] STIFFNESS_RESET = 16'd15360;
  localparam logic [15:0] DAMPING_RESET   = 16'd1280;

  // Fixed poses in signed Q3.12 radians
  localparam logic signed [ANGLE_BITS-1:0] POSE_TABLE [0:POSE_COUNT-1][0:JOINT_COUNT-1] = '{
    '{16'sd0, 16'sd5571, -16'sd10854, 16'sd0, 16'sd5571, -16'sd10854,
      -16'sd819, 16'sd5571, -16'sd10854, 16'sd819, 16'sd5571, -16'sd10854},
    '{16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325,
      16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325},
    '{-16'sd1434, 16'sd5571, -16'sd10854, 16'sd1434, 16'sd5571, -16'sd10854,
      -16'sd2048, 16'sd5571, -16'sd10854, 16'sd2048, 16'sd5571, -16'sd10854}
  };

  typedef struct packed {
    logic                 start;
    logic [FRAC_BITS-1:0] x;
    logic [15:0]          d;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                        start;
    logic signed [ANGLE_BITS-1:0] a;
    logic signed [ANGLE_BITS-1:0] b;
    logic [FRAC_BITS-1:0]        frac;
  } interp_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [ANGLE_BITS-1:0] target;
  } interp_rsp_t;

endpackage

// ===== sv/kji_in_if.sv =====
// Input channel: measurement and tick items.
interface kji_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [kji_pkg::JOINT_BITS-1:0]      joint;
  logic signed [kji_pkg::ANGLE_BITS-1:0] measured_angle;

  modport source (output valid, output cmd, output joint, output measured_angle, input ready);
  modport sink (input valid, input cmd, input joint, input measured_angle, output ready);
endinterface

// ===== sv/kji_out_if.sv =====
// Output channel: one joint target per item.
interface kji_out_if;
  logic                                valid;
  logic                                ready;
  logic [kji_pkg::JOINT_BITS-1:0]      joint_out;
  logic signed [kji_pkg::ANGLE_BITS-1:0] target_angle;
  logic [kji_pkg::GAIN_BITS-1:0]       stiffness;
  logic [kji_pkg::GAIN_BITS-1:0]       damping;
  logic                                motion_done;
  logic                                last;

  modport source (output valid, output joint_out, output target_angle, output stiffness,
                  output damping, output motion_done, output last, input ready);
  modport sink (input valid, input joint_out, input target_angle, input stiffness,
                input damping, input motion_done, input last, output ready);
endinterface

// ===== sv/keyframe_joint_interpolator_unit.sv =====
// Three-segment keyframe trajectory generator for twelve joints.
// A measurement item is taken in the idle state; once the motion is done a tick passes each
// joint through the start and emit states. Otherwise a tick runs the segment search and the
// bit-serial divider, then each joint through the 4-bit digit-serial interpolator.
// Output stalls stretch the tick. Synchronous reset restores register defaults and clears
// angles, tick counter, finished flag and output valid, and sets the first-tick flag.
module keyframe_joint_interpolator_unit (
  input  logic        clk,
  input  logic        rst,
  kji_in_if.sink      in_ch,
  kji_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_MWAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [15:0] seg_ticks [0:kji_pkg::POSE_COUNT-1];
  logic [15:0] stiffness_gain;
  logic [15:0] damping_gain;

  logic signed [kji_pkg::ANGLE_BITS-1:0] latest_angle [0:kji_pkg::JOINT_COUNT-1];
  logic signed [kji_pkg::ANGLE_BITS-1:0] start_angle [0:kji_pkg::JOINT_COUNT-1];

  logic [kji_pkg::TICK_BITS-1:0]  tick_count;
  logic [kji_pkg::TICK_BITS-1:0]  offset;
  logic                           first_tick;
  logic                           finished;
  logic [kji_pkg::SEG_BITS-1:0]   seg;
  logic [kji_pkg::SEG_BITS-1:0]   seg_prev;
  logic [kji_pkg::JOINT_BITS-1:0] jidx;
  logic [kji_pkg::FRAC_BITS-1:0]  frac;
  logic signed [kji_pkg::ANGLE_BITS-1:0] target;

  logic [15:0]                   seg_len;
  logic [kji_pkg::TICK_BITS:0]   seg_end;
  logic                          hit;
  logic                          in_fire;
  logic                          out_free;
  logic signed [kji_pkg::ANGLE_BITS-1:0] from_angle;

  kji_pkg::div_req_t    div_req;
  kji_pkg::div_rsp_t    div_rsp;
  kji_pkg::interp_req_t ip_req;
  kji_pkg::interp_rsp_t ip_rsp;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  always_comb begin
    seg_len  = seg_ticks[seg];
    seg_end  = {1'b0, offset} + 19'(seg_len);
    hit      = {1'b0, tick_count} <= seg_end;
    seg_prev = seg - 2'd1;
    if (seg == 2'd0) begin
      from_angle = first_tick ? latest_angle[jidx] : start_angle[jidx];
    end else begin
      from_angle = kji_pkg::POSE_TABLE[seg_prev][jidx];
    end
  end

  always_comb begin
    div_req.start = (state == ST_SEARCH) && hit;
    div_req.x     = 17'(tick_count - offset);
    div_req.d     = seg_len;
    ip_req.start  = (state == ST_MSTART) && !finished;
    ip_req.a      = from_angle;
    ip_req.b      = kji_pkg::POSE_TABLE[seg][jidx];
    ip_req.frac   = frac;
  end

  kji_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kji_interp u_interp (
    .clk (clk),
    .rst (rst),
    .req (ip_req),
    .rsp (ip_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_ch.cmd == kji_pkg::CMD_TICK)) begin
          state_next = finished ? ST_MSTART : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_next = ST_DIV;
        end else if (seg == kji_pkg::LAST_SEG) begin
          state_next = ST_MSTART;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_MSTART;
        end
      end
      ST_MSTART: begin
        state_next = finished ? ST_EMIT : ST_MWAIT;
      end
      ST_MWAIT: begin
        if (ip_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (jidx == kji_pkg::LAST_JOINT) ? ST_IDLE : ST_MSTART;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      seg_ticks[0]   <= kji_pkg::SEG_ONE_RESET;
      seg_ticks[1]   <= kji_pkg::SEG_TWO_RESET;
      seg_ticks[2]   <= kji_pkg::SEG_THREE_RESET;
      stiffness_gain <= kji_pkg::STIFFNESS_RESET;
      damping_gain   <= kji_pkg::DAMPING_RESET;
      tick_count     <= '0;
      offset         <= '0;
      first_tick     <= 1'b1;
      finished       <= 1'b0;
      seg            <= '0;
      jidx           <= '0;
      out_ch.valid   <= 1'b0;
      for (int i = 0; i < kji_pkg::JOINT_COUNT; i++) begin
        latest_angle[i] <= '0;
        start_angle[i]  <= '0;
      end
    end else begin
      state <= state_next;
      // In the emit state the output register is reloaded below
      if (out_ch.valid && out_ch.ready && (state != ST_EMIT)) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          kji_pkg::REG_SEG_ONE:   seg_ticks[0]   <= cfg_data;
          kji_pkg::REG_SEG_TWO:   seg_ticks[1]   <= cfg_data;
          kji_pkg::REG_SEG_THREE: seg_ticks[2]   <= cfg_data;
          kji_pkg::REG_STIFFNESS: stiffness_gain <= cfg_data;
          kji_pkg::REG_DAMPING:   damping_gain   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.cmd == kji_pkg::CMD_MEASURE) begin
              if (in_ch.joint <= kji_pkg::LAST_JOINT) begin
                latest_angle[in_ch.joint] <= in_ch.measured_angle;
              end
            end else begin
              if (tick_count != '1) begin
                tick_count <= tick_count + 18'd1;
              end
              offset <= '0;
              seg    <= '0;
              jidx   <= '0;
            end
          end
        end
        ST_SEARCH: begin
          if (!hit) begin
            offset <= seg_end[kji_pkg::TICK_BITS-1:0];
            if (seg == kji_pkg::LAST_SEG) begin
              finished <= 1'b1;
            end else begin
              seg <= seg + 2'd1;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            frac <= div_rsp.quot;
          end
        end
        ST_MSTART: begin
          if (finished) begin
            target <= kji_pkg::POSE_TABLE[kji_pkg::LAST_SEG][jidx];
          end
        end
        ST_MWAIT: begin
          if (ip_rsp.done) begin
            target <= ip_rsp.target;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.joint_out    <= jidx;
            out_ch.target_angle <= target;
            out_ch.stiffness    <= stiffness_gain;
            out_ch.damping      <= damping_gain;
            out_ch.motion_done  <= finished;
            out_ch.last         <= (jidx == kji_pkg::LAST_JOINT);
            // Latch start positions joint by joint on the first tick
            if (first_tick) begin
              start_angle[jidx] <= latest_angle[jidx];
            end
            if (jidx == kji_pkg::LAST_JOINT) begin
              first_tick <= 1'b0;
            end else begin
              jidx <= jidx + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_joint: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.last == (out_ch.joint_out == kji_pkg::LAST_JOINT)))
    else $error("last flag does not match joint index");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (div_rsp.quot <= 17'h10000))
    else $error("segment fraction above one");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");
`endif

endmodule

// ===== sv/kji_div.sv =====
// Bit-serial restoring divider for the segment fraction (x << 16) / d.
module kji_div (
  input  logic              clk,
  input  logic              rst,
  input  kji_pkg::div_req_t req,
  output kji_pkg::div_rsp_t rsp
);

  logic [kji_pkg::FRAC_BITS-1:0] rem;
  logic [kji_pkg::FRAC_BITS-1:0] quot;
  logic [15:0]                   dvs;
  logic [4:0]                    cnt;
  logic                          busy;
  logic                          done;
  logic [kji_pkg::FRAC_BITS-1:0] trial;
  logic                          ge;

  // x never exceeds d, so the first step needs no shift
  always_comb begin
    trial = (cnt == 5'd0) ? rem : {rem[kji_pkg::FRAC_BITS-2:0], 1'b0};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'(kji_pkg::FRAC_BITS - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 5'(kji_pkg::FRAC_BITS - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.x;
      dvs  <= req.d;
      cnt  <= 5'd0;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? (trial - {1'b0, dvs}) : trial;
      quot <= {quot[kji_pkg::FRAC_BITS-2:0], ge};
      cnt  <= cnt + 5'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ===== sv/kji_interp.sv =====
// Digit-serial linear interpolation a + floor((b - a) * frac / 65536), saturated.
module kji_interp (
  input  logic                 clk,
  input  logic                 rst,
  input  kji_pkg::interp_req_t req,
  output kji_pkg::interp_rsp_t rsp
);

  localparam int SR_BITS  = kji_pkg::DIGIT_BITS * kji_pkg::DIGITS;
  localparam int ACC_BITS = 36;

  logic signed [kji_pkg::ANGLE_BITS:0]   diff;
  logic signed [kji_pkg::ANGLE_BITS-1:0] a_r;
  logic [SR_BITS-1:0]                    sr;
  logic signed [ACC_BITS-1:0]            acc;
  logic [2:0]                            cnt;
  logic                                  busy;
  logic                                  done;
  logic signed [21:0]                    prod;
  logic signed [19:0]                    sum;
  logic signed [kji_pkg::ANGLE_BITS-1:0] sat;

  always_comb begin
    prod = diff * $signed({1'b0, sr[SR_BITS-1 -: kji_pkg::DIGIT_BITS]});
    sum  = 20'(a_r) + $signed(acc[35:16]);
    if (sum > 20'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 3'(kji_pkg::DIGITS - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 3'(kji_pkg::DIGITS - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  // Most significant digit first: shift the sum up one digit, add the next partial product
  always_ff @(posedge clk) begin
    if (req.start) begin
      diff <= 17'(req.b) - 17'(req.a);
      a_r  <= req.a;
      sr   <= SR_BITS'(req.frac);
      acc  <= '0;
      cnt  <= 3'd0;
    end else if (busy) begin
      acc <= (acc <<< kji_pkg::DIGIT_BITS) + ACC_BITS'(prod);
      sr  <= sr << kji_pkg::DIGIT_BITS;
      cnt <= cnt + 3'd1;
    end
  end

  assign rsp.done   = done;
  assign rsp.target = sat;

endmodule

// ===== dv/testbench.sv =====
// Testbench for the keyframe joint interpolator: directed rows, then random trajectory phases.
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] REG_FIRST_UNMAPPED = 3'd5;

  localparam int MAX_GAP          = 15;
  localparam int SETTLE_CYCLES    = 150;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS      = 48;
  localparam int RANDOM_PHASES    = 8;
  localparam int FINISH_ITEMS     = 26;
  localparam logic [kji_pkg::TICK_BITS-1:0] TICK_LIMIT = '1;

  // Key poses in Q3.12, nearest value of each angle in radians
  localparam logic signed [15:0] KEY_POSE [0:2][0:11] = '{
    '{16'sd0, 16'sd5571, -16'sd10854, 16'sd0, 16'sd5571, -16'sd10854,
      -16'sd819, 16'sd5571, -16'sd10854, 16'sd819, 16'sd5571, -16'sd10854},
    '{16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325,
      16'sd0, 16'sd2744, -16'sd5325, 16'sd0, 16'sd2744, -16'sd5325},
    '{-16'sd1434, 16'sd5571, -16'sd10854, 16'sd1434, 16'sd5571, -16'sd10854,
      -16'sd2048, 16'sd5571, -16'sd10854, 16'sd2048, 16'sd5571, -16'sd10854}
  };

  typedef enum logic [1:0] {ROW_MEASURE, ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [3:0]  sel;
    logic [15:0] value;
    bit          typed;
    int          pose;
    logic [15:0] stiff;
    logic [15:0] damp;
    logic        done;
  } script_row_t;

  typedef struct packed {
    logic [kji_pkg::JOINT_BITS-1:0]        joint;
    logic signed [kji_pkg::ANGLE_BITS-1:0] angle;
    logic [kji_pkg::GAIN_BITS-1:0]         stiff;
    logic [kji_pkg::GAIN_BITS-1:0]         damp;
    logic                                  done;
    logic                                  last;
  } joint_target_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  kji_in_if  in_ch ();
  kji_out_if out_ch ();

  keyframe_joint_interpolator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Trajectory predictor state
  logic signed [15:0]             measured_q [12];
  logic signed [15:0]             launch_q [12];
  logic signed [15:0]             aim [12];
  logic [kji_pkg::TICK_BITS-1:0]  tick_cnt;
  bit                             awaiting_first_tick;
  bit                             motion_finished;
  logic [15:0]                    seg_len [3];
  logic [15:0]                    stiff_gain;
  logic [15:0]                    damp_gain;

  joint_target_t pending_targets [$];
  int            mismatch_count;
  bit            sender_idles;
  bit            receiver_idles;
  bit            block_touched;
  int            long_hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic script_row_t row(row_kind_t kind, logic [3:0] sel = 4'd0,
                                      logic [15:0] value = 16'd0, bit typed = 1'b0,
                                      int pose = 0, logic [15:0] stiff = 16'd0,
                                      logic [15:0] damp = 16'd0, logic done = 1'b0);
    script_row_t r;
    r.kind  = kind;
    r.sel   = sel;
    r.value = value;
    r.typed = typed;
    r.pose  = pose;
    r.stiff = stiff;
    r.damp  = damp;
    r.done  = done;
    return r;
  endfunction

  function automatic logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                               logic [16:0] frac);
    longint span;
    longint sum;
    span = (longint'(b) - longint'(a)) * longint'(frac);
    // arithmetic shift floors toward minus infinity
    sum = longint'(a) + (span >>> 16);
    if (sum > 32767) sum = 32767;
    else if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic advance_trajectory();
    longint      offset;
    logic [16:0] frac;
    bit          found;
    offset = 0;
    found  = 1'b0;
    if (awaiting_first_tick) begin
      for (int j = 0; j < 12; j++) launch_q[j] = measured_q[j];
      awaiting_first_tick = 1'b0;
    end
    if (tick_cnt != TICK_LIMIT) tick_cnt++;
    if (!motion_finished) begin
      for (int s = 0; s < 3; s++) begin
        if (!found && longint'(tick_cnt) <= offset + longint'(seg_len[s])) begin
          if (seg_len[s] == 16'd0) frac = 17'd65536;
          else frac = 17'(((longint'(tick_cnt) - offset) << 16) / longint'(seg_len[s]));
          for (int j = 0; j < 12; j++)
            aim[j] = blend((s == 0) ? launch_q[j] : KEY_POSE[s-1][j], KEY_POSE[s][j], frac);
          found = 1'b1;
        end
        offset += longint'(seg_len[s]);
      end
      if (!found) motion_finished = 1'b1;
    end
    if (motion_finished)
      for (int j = 0; j < 12; j++) aim[j] = KEY_POSE[2][j];
  endtask

  task automatic queue_targets(input logic [15:0] stiff, input logic [15:0] damp,
                               input logic done);
    joint_target_t t;
    for (int j = 0; j < 12; j++) begin
      t.joint = kji_pkg::JOINT_BITS'(j);
      t.angle = aim[j];
      t.stiff = stiff;
      t.damp  = damp;
      t.done  = done;
      t.last  = (j == 11);
      pending_targets.push_back(t);
    end
  endtask

  // Drop valid, wait for every target, then let the block go quiet
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    block_touched = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] reg_index, input logic [15:0] value);
    if (block_touched) settle_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (reg_index)
      kji_pkg::REG_SEG_ONE:   seg_len[0] = value;
      kji_pkg::REG_SEG_TWO:   seg_len[1] = value;
      kji_pkg::REG_SEG_THREE: seg_len[2] = value;
      kji_pkg::REG_STIFFNESS: stiff_gain = value;
      kji_pkg::REG_DAMPING:   damp_gain  = value;
      default: ;
    endcase
  endtask

  task automatic send_item(input logic cmd, input logic [3:0] joint, input logic [15:0] angle);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.joint          <= joint;
    in_ch.measured_angle <= angle;
    do @(posedge clk); while (!in_ch.ready);
    block_touched = 1'b1;
  endtask

  task automatic run_row(input script_row_t r);
    case (r.kind)
      ROW_CFG: write_reg(r.sel[2:0], r.value);
      ROW_MEASURE: begin
        send_item(kji_pkg::CMD_MEASURE, r.sel, r.value);
        if (r.sel < kji_pkg::JOINT_COUNT) measured_q[r.sel] = r.value;
      end
      default: begin
        send_item(kji_pkg::CMD_TICK, r.sel, r.value);
        advance_trajectory();
        if (r.typed) begin
          for (int j = 0; j < 12; j++) aim[j] = KEY_POSE[r.pose][j];
          queue_targets(r.stiff, r.damp, r.done);
        end else begin
          queue_targets(stiff_gain, damp_gain, motion_finished);
        end
      end
    endcase
  endtask

  function automatic script_row_t random_row(bit tick);
    if (tick) return row(ROW_TICK, 4'($urandom()), 16'($urandom()));
    return row(ROW_MEASURE, 4'($urandom_range(0, 15)), 16'($urandom()));
  endfunction

  // Target receiver: random stalls plus one long hold-off
  initial begin : take_targets
    int stall;
    joint_target_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_targets.size() == 0) begin
          $error("target item with nothing expected: joint_out %0d", out_ch.joint_out);
          mismatch_count++;
        end else begin
          want = pending_targets.pop_front();
          check_field("joint_out", 32'(want.joint), 32'(out_ch.joint_out));
          check_field("target_angle", 32'($signed(want.angle)),
                      32'($signed(out_ch.target_angle)));
          check_field("stiffness", 32'(want.stiff), 32'(out_ch.stiffness));
          check_field("damping", 32'(want.damp), 32'(out_ch.damping));
          check_field("motion_done", 32'(want.done), 32'(out_ch.motion_done));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
        stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    script_row_t script [$];
    int t0;
    int b1;
    int s2;
    int s3;
    int rest;

    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= kji_pkg::CMD_MEASURE;
    in_ch.joint          <= '0;
    in_ch.measured_angle <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= kji_pkg::REG_SEG_ONE;
    cfg_data             <= '0;

    for (int j = 0; j < 12; j++) begin
      measured_q[j] = '0;
      launch_q[j]   = '0;
      aim[j]        = '0;
    end
    tick_cnt            = '0;
    awaiting_first_tick = 1'b1;
    motion_finished     = 1'b0;
    seg_len[0]          = kji_pkg::SEG_ONE_RESET;
    seg_len[1]          = kji_pkg::SEG_TWO_RESET;
    seg_len[2]          = kji_pkg::SEG_THREE_RESET;
    stiff_gain          = kji_pkg::STIFFNESS_RESET;
    damp_gain           = kji_pkg::DAMPING_RESET;
    mismatch_count      = 0;
    sender_idles        = 1'b1;
    receiver_idles      = 1'b1;
    block_touched       = 1'b0;
    long_hold_left      = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Start angles at the extremes; the unmapped joints must leave them alone
    script.push_back(row(ROW_MEASURE, 4'd0, 16'd100));
    script.push_back(row(ROW_MEASURE, 4'd0, 16'h7FFF));
    script.push_back(row(ROW_MEASURE, 4'd1, 16'h8000));
    script.push_back(row(ROW_MEASURE, 4'd2, 16'hFFFF));
    script.push_back(row(ROW_MEASURE, 4'd3, 16'h0001));
    script.push_back(row(ROW_MEASURE, 4'd4, 16'h5555));
    script.push_back(row(ROW_MEASURE, 4'd5, 16'hAAAA));
    script.push_back(row(ROW_MEASURE, 4'd6, 16'h7FFF));
    script.push_back(row(ROW_MEASURE, 4'd7, 16'h8000));
    script.push_back(row(ROW_MEASURE, 4'd8, 16'd12345));
    script.push_back(row(ROW_MEASURE, 4'd9, 16'hCFC7));
    script.push_back(row(ROW_MEASURE, 4'd10, 16'h7000));
    script.push_back(row(ROW_MEASURE, 4'd11, 16'hFFFE));
    script.push_back(row(ROW_MEASURE, 4'd12, 16'd999));
    script.push_back(row(ROW_MEASURE, 4'd15, 16'h8000));
    script.push_back(row(ROW_TICK));
    // Each typed tick below lands exactly on a segment end
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_ONE), 16'd2));
    script.push_back(row(ROW_TICK, 4'd0, 16'd0, 1'b1, 0, kji_pkg::STIFFNESS_RESET,
                         kji_pkg::DAMPING_RESET, 1'b0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_TWO), 16'd1));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_THREE), 16'hFFFF));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_STIFFNESS), 16'd0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_DAMPING), 16'hFFFF));
    script.push_back(row(ROW_TICK, 4'd0, 16'd0, 1'b1, 1, 16'd0, 16'hFFFF, 1'b0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_THREE), 16'd1));
    script.push_back(row(ROW_TICK, 4'd0, 16'd0, 1'b1, 2, 16'd0, 16'hFFFF, 1'b0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_ONE), 16'hFFFF));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_STIFFNESS), 16'hFFFF));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_DAMPING), 16'd0));
    script.push_back(row(ROW_TICK));
    // Zero-length segments are skipped; writes past the register list do nothing
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_ONE), 16'd0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_TWO), 16'd0));
    script.push_back(row(ROW_CFG, 4'(kji_pkg::REG_SEG_THREE), 16'hFFFF));
    script.push_back(row(ROW_CFG, 4'(REG_FIRST_UNMAPPED), 16'd1));
    script.push_back(row(ROW_CFG, 4'(REG_FIRST_UNMAPPED + 3'd1), 16'd1));
    script.push_back(row(ROW_CFG, 4'(REG_FIRST_UNMAPPED + 3'd2), 16'd1));
    script.push_back(row(ROW_TICK, 4'd9, 16'h1234));

    foreach (script[i]) run_row(script[i]);

    // Random phases: place segment ends around the coming ticks, never past the last one
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_idles   = (phase % 4 == 0) || (phase % 4 == 2);
      receiver_idles = (phase % 4 < 2);
      t0   = int'(tick_cnt);
      b1   = $urandom_range(1, t0 + PHASE_ITEMS);
      s2   = $urandom_range(1, PHASE_ITEMS / 2);
      rest = t0 + PHASE_ITEMS + 1 - b1 - s2;
      s3   = $urandom_range(1, PHASE_ITEMS);
      if (s3 < rest) s3 = rest;
      run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_ONE), 16'(b1)));
      run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_TWO), 16'(s2)));
      run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_THREE), 16'(s3)));
      run_row(row(ROW_CFG, 4'(kji_pkg::REG_STIFFNESS), 16'($urandom())));
      run_row(row(ROW_CFG, 4'(kji_pkg::REG_DAMPING), 16'($urandom())));
      // hold the receiver off while the sender keeps offering ticks
      if (phase == 1) long_hold_left = LONG_HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 4 && k == PHASE_ITEMS / 2) settle_idle();
        run_row(random_row($urandom_range(0, 9) < 7));
      end
    end

    // Last phase: a short final segment, then finish and hold the final pose
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    t0 = int'(tick_cnt);
    b1 = $urandom_range(1, t0 - 2);
    run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_ONE), 16'(b1)));
    run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_TWO), 16'(t0 - 1 - b1)));
    run_row(row(ROW_CFG, 4'(kji_pkg::REG_SEG_THREE), 16'd4));
    for (int k = 0; k < FINISH_ITEMS; k++)
      run_row(random_row(k < 6 || $urandom_range(0, 9) < 7));

    settle_idle();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kji_pkg.sv
sv/kji_in_if.sv
sv/kji_out_if.sv
sv/kji_div.sv
sv/kji_interp.sv
sv/keyframe_joint_interpolator_unit.sv
dv/testbench.sv
